### rtl/moving_average_x100_unit_macros.svh
// Assertion macros shared by the moving average RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MOVING_AVERAGE_X100_UNIT_MACROS_SVH
`define MOVING_AVERAGE_X100_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAVG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mavg_pkg.sv
// Types and fixed constants of the moving average unit.
// Depends on nothing; imported by moving_average_x100_unit.
package mavg_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WS_W      = 9;
  localparam int SCALE     = 100;
  localparam int SCALE_W   = 7;
  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN_MAG = 32768;
  localparam int USER_W    = 2;

  localparam logic [WS_W-1:0] WS_RESET = 9'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

### rtl/moving_average_x100_unit.sv
// Moving average over a sample ring, scaled by 100, with a bit-serial divider.
// Depends on mavg_pkg and moving_average_x100_unit_macros.svh.
//
// Usage: signed 16-bit samples arrive on the s_axis request channel, one
// result leaves on m_axis per sample: the window average times 100,
// truncated toward zero and saturated to int16, with tuser flags for an
// overwritten oldest sample and for saturation. The window size is written
// on the cfg channel only while the block is idle, ahead of a waiting sample;
// any write clears the sum, the fill count and the ring pointer.
// Steps: after a sample is accepted, the ring and sum update in ST_UPD, the
// scaling by 100 follows in ST_MUL, then a restoring divider produces one
// quotient bit per cycle over the scaled sum width ($clog2(WINDOW_MAX) + 23
// bits, 31 at the default), and ST_FIN loads the output register once it is
// free. s_axis_tready is low meanwhile and returns in the same cycle as the
// result, so no new sample is taken until the previous one has left ST_FIN.
// Reset: window size 1, sum, fill count and pointer zero; ring contents are
// unknown but never read before written.
// Stall: the result sits in an output register. A new sample is accepted
// while it waits; the next result holds in the final step until the
// receiver takes the pending one.
`include "moving_average_x100_unit_macros.svh"

module moving_average_x100_unit
  import mavg_pkg::*;
#(
  parameter int WINDOW_MAX = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata,  // [15:0] average_x100
  output logic [USER_W-1:0]   m_axis_tuser,  // [0] overwrote, [1] saturated
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WS_W-1:0]     cfg_data       // [8:0] window_size
);

  localparam int PW       = $clog2(WINDOW_MAX);
  localparam int EW       = $clog2(WINDOW_MAX + 1);
  localparam int CW       = (EW > WS_W) ? EW : WS_W;
  localparam int SUM_W    = PW + SAMPLE_W;
  localparam int SCALED_W = SUM_W + SCALE_W;
  localparam int CNT_W    = $clog2(SCALED_W);

  state_t state, state_next;

  logic [WS_W-1:0]     window_size;
  logic [EW-1:0]       w_eff;
  logic [PW-1:0]       write_pointer;
  logic [EW-1:0]       fill_count;
  logic signed [SUM_W-1:0] running_sum;

  logic [SAMPLE_W-1:0] ring [WINDOW_MAX];
  logic [SAMPLE_W-1:0] ring_rd;
  logic [SAMPLE_W-1:0] sample_q;
  logic [PW-1:0]       slot_q;
  logic                dropped_q;

  logic [EW-1:0]       slot_ext;
  logic [EW-1:0]       slot_inc;

  logic signed [SCALED_W-1:0] scaled;
  logic                neg_q;
  logic [SCALED_W-1:0] dq;
  logic [EW-1:0]       rem;
  logic [CNT_W-1:0]    cnt;
  logic [EW:0]         rem_shift;
  logic [EW:0]         rem_trial;

  logic                in_acc;
  logic                cfg_acc;
  logic                load_out;

  logic [SAMPLE_W-1:0] avg_val;
  logic                sat_val;

  always_comb begin
    logic [CW-1:0] ws_ext;
    ws_ext = CW'(window_size);
    if (window_size == '0) begin
      w_eff = EW'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      w_eff = EW'(WINDOW_MAX);
    end else begin
      w_eff = EW'(ws_ext);
    end
  end

  assign slot_ext = (EW'(write_pointer) >= w_eff) ? '0 : EW'(write_pointer);
  assign slot_inc = EW'(slot_q) + EW'(1);

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cfg_acc = cfg_valid & cfg_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_UPD;
      ST_UPD:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_FIN;
      ST_FIN:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !cfg_valid;
        cfg_ready     = 1'b1;
      end
      ST_FIN:  load_out = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_rd <= ring[PW'(slot_ext)];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      ring[slot_q] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WS_RESET;
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (cfg_acc) begin
      window_size   <= cfg_data;
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (state == ST_UPD) begin
      running_sum <= running_sum + SUM_W'($signed(sample_q))
                     - (dropped_q ? SUM_W'($signed(ring_rd)) : SUM_W'(0));
      fill_count    <= dropped_q ? w_eff : fill_count + EW'(1);
      write_pointer <= (slot_inc >= w_eff) ? '0 : PW'(slot_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_q  <= s_axis_tdata;
      slot_q    <= PW'(slot_ext);
      dropped_q <= fill_count >= w_eff;
    end
  end

  assign scaled    = SCALED_W'(running_sum) * SCALED_W'(SCALE);
  assign rem_shift = {rem, dq[SCALED_W-1]};
  assign rem_trial = rem_shift - {1'b0, fill_count};

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      neg_q <= scaled[SCALED_W-1];
      dq    <= scaled[SCALED_W-1] ? SCALED_W'(-scaled) : SCALED_W'(scaled);
      rem   <= '0;
      cnt   <= CNT_W'(SCALED_W - 1);
    end else if (state == ST_DIV) begin
      cnt <= cnt - CNT_W'(1);
      if (!rem_trial[EW]) begin
        rem <= rem_trial[EW-1:0];
        dq  <= {dq[SCALED_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[EW-1:0];
        dq  <= {dq[SCALED_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg_q && (dq > SCALED_W'(SAT_MAX))) begin
      avg_val = SAMPLE_W'(SAT_MAX);
      sat_val = 1'b1;
    end else if (neg_q && (dq > SCALED_W'(SAT_MIN_MAG))) begin
      avg_val = SAMPLE_W'(SAT_MIN_MAG);
      sat_val = 1'b1;
    end else if (neg_q) begin
      avg_val = SAMPLE_W'(-dq);
      sat_val = 1'b0;
    end else begin
      avg_val = SAMPLE_W'(dq);
      sat_val = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= avg_val;
      m_axis_tuser <= {sat_val, dropped_q};
    end
  end

  `MAVG_ASSERT_IMP(a_fill_in_window, clk, rst, 1'b1, fill_count <= w_eff,
    "Fill count exceeds the window.")
  `MAVG_ASSERT_IMP(a_ptr_in_window, clk, rst, state == ST_IDLE,
    EW'(write_pointer) < w_eff, "Write pointer outside the window.")
  `MAVG_ASSERT_IMP(a_divisor_nonzero, clk, rst, state == ST_DIV, fill_count != '0,
    "Divider runs with a zero divisor.")
  `MAVG_ASSERT_NEXT(a_accept_busy, clk, rst, in_acc, state == ST_UPD,
    "Accepted sample did not start the update.")
  `MAVG_ASSERT_IMP(a_sat_bound, clk, rst, m_axis_tvalid && m_axis_tuser[1],
    (m_axis_tdata == 16'h7FFF) || (m_axis_tdata == 16'h8000),
    "Saturated result is not at an int16 bound.")

endmodule
